// File: sv/isd_pkg.sv
// ----------------------------------------------------------------------------
// isd_pkg
// Shared types, sizes and the seed vertex table of the icosphere subdivider.
// ----------------------------------------------------------------------------
package isd_pkg;

  localparam int unsigned IdxW       = 14;
  localparam int unsigned CountW     = 15;
  localparam int unsigned LevelW     = 3;
  localparam int unsigned CoordW     = 16;
  localparam int unsigned VtxW       = 3 * CoordW;
  localparam int unsigned EntryW     = 1 + 3 * IdxW;
  localparam int unsigned StoreDepth = 16384;
  localparam int unsigned CacheDepth = 16384;
  localparam int unsigned SeedCount  = 12;
  localparam logic [LevelW-1:0] MaxLevel = 3'd5;
  localparam logic [CoordW-1:0] OneQ14   = 16'd16384;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StStoreFull = 2'd1,
    StCacheFull = 2'd2,
    StRange     = 2'd3
  } status_e;

  typedef enum logic {
    ReqSplit = 1'b0,
    ReqRead  = 1'b1
  } req_type_e;

  typedef struct packed {
    logic              req_type;
    logic [IdxW-1:0]   corner_a;
    logic [IdxW-1:0]   corner_b;
    logic [IdxW-1:0]   corner_c;
    logic [LevelW-1:0] face_level;
  } req_t;

  typedef struct packed {
    logic [IdxW-1:0]          out_a;
    logic [IdxW-1:0]          out_b;
    logic [IdxW-1:0]          out_c;
    logic [LevelW-1:0]        out_level;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic [1:0]               status;
    logic                     last;
  } res_t;

  function automatic logic [VtxW-1:0] seed_vtx(input logic [3:0] k);
    logic [CoordW-1:0] pi;
    logic [CoordW-1:0] pa;
    logic [CoordW-1:0] ni;
    logic [CoordW-1:0] na;
    logic [CoordW-1:0] zr;
    pi = 16'd8614;
    pa = 16'd13937;
    ni = 16'(-16'sd8614);
    na = 16'(-16'sd13937);
    zr = '0;
    case (k)
      4'd0:    return {ni, pa, zr};
      4'd1:    return {pi, pa, zr};
      4'd2:    return {ni, na, zr};
      4'd3:    return {pi, na, zr};
      4'd4:    return {zr, ni, pa};
      4'd5:    return {zr, pi, pa};
      4'd6:    return {zr, ni, na};
      4'd7:    return {zr, pi, na};
      4'd8:    return {pa, zr, ni};
      4'd9:    return {pa, zr, pi};
      4'd10:   return {na, zr, ni};
      4'd11:   return {na, zr, pi};
      default: return '0;
    endcase
  endfunction

endpackage

// File: sv/icosphere_face_subdivider.sv
// ----------------------------------------------------------------------------
// icosphere_face_subdivider
// Splits icosphere faces with a hashed edge-midpoint cache and a vertex store.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all 16384 cache slots that
// empties the edge cache and loads the twelve seed vertices; busy is high
// meanwhile. A read request passes through SRdv and SRdOut. A split request
// probes the cache per edge; each new midpoint takes the 30-step square root
// and three 16-step divisions of the shared normalizer. Results appear one
// per cycle on result_o while result_valid_o is high; they cannot be held off.
module icosphere_face_subdivider import isd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  req_t              req_i,
  input  logic              cfg_we_i,
  input  logic [LevelW-1:0] cfg_wdata_i,
  output logic              result_valid_o,
  output res_t              result_o
);

  typedef enum logic [15:0] {
    SInit  = 16'h0001,
    SIdle  = 16'h0002,
    SRdv   = 16'h0004,
    SRdOut = 16'h0008,
    SEdge  = 16'h0010,
    SProbe = 16'h0020,
    SChk   = 16'h0040,
    SRdp   = 16'h0080,
    SRdq   = 16'h0100,
    SSum   = 16'h0200,
    SSq    = 16'h0400,
    SSqrt  = 16'h0800,
    SDivI  = 16'h1000,
    SDiv   = 16'h2000,
    SWr    = 16'h4000,
    SEmit  = 16'h8000
  } state_e;

  function automatic logic signed [16:0] sext17(input logic [CoordW-1:0] v);
    return {v[CoordW-1], v};
  endfunction

  state_e                   state_q, state_d;
  logic [IdxW-1:0]          init_q, init_d;
  logic [LevelW-1:0]        tgt_q;
  logic [CountW-1:0]        count_q, count_d;
  req_t                     req_q, req_d;
  logic [1:0]               edge_q, edge_d;
  logic [IdxW-1:0]          p_q, p_d, q_q, q_d, lo_q, lo_d, hi_q, hi_d, slot_q, slot_d;
  logic [2:0][IdxW-1:0]     mid_q, mid_d;
  logic [VtxW-1:0]          av_q, av_d;
  logic signed [16:0]       sx_q, sx_d, sy_q, sy_d, sz_q, sz_d;
  logic [1:0]               cnt2_q, cnt2_d;
  logic [31:0]              s_q, s_d;
  logic [59:0]              v_q, v_d, r_q, r_d, bit_q, bit_d;
  logic [46:0]              num_q, num_d, dvs_q, dvs_d;
  logic [15:0]              quo_q, quo_d;
  logic [3:0]               dcnt_q, dcnt_d;
  logic [2:0][CoordW-1:0]   nv_q, nv_d;
  logic                     ov_q, ov_d;
  res_t                     out_q, out_d;

  logic                     vwe, cwe;
  logic [IdxW-1:0]          vwaddr, vraddr, cwaddr;
  logic [VtxW-1:0]          vwdata, vrdata;
  logic [EntryW-1:0]        cwdata, crdata;

  logic [LevelW-1:0]        tgt_eff;
  logic [IdxW-1:0]          ep, eq, elo, ehi;
  logic signed [16:0]       csel;
  logic [15:0]              mag;
  logic signed [33:0]       prod;
  logic [31:0]              s_next;
  logic [60:0]              trial;
  logic [15:0]              quo_n, qsat;
  logic [30:0]              len;
  res_t                     zres;

  isd_ram #(.Width(VtxW), .Depth(StoreDepth)) u_vstore (
    .clk_i   (clk_i),
    .we_i    (vwe),
    .waddr_i (vwaddr),
    .wdata_i (vwdata),
    .raddr_i (vraddr),
    .rdata_o (vrdata)
  );

  isd_ram #(.Width(EntryW), .Depth(CacheDepth)) u_ecache (
    .clk_i   (clk_i),
    .we_i    (cwe),
    .waddr_i (cwaddr),
    .wdata_i (cwdata),
    .raddr_i (slot_q),
    .rdata_o (crdata)
  );

  assign busy           = (state_q != SIdle);
  assign result_valid_o = ov_q;
  assign result_o       = out_q;
  assign tgt_eff        = (tgt_q < MaxLevel) ? tgt_q : MaxLevel;
  assign len            = r_q[30:0];

  always_comb begin
    case (edge_q)
      2'd0: begin
        ep = req_q.corner_a;
        eq = req_q.corner_b;
      end
      2'd1: begin
        ep = req_q.corner_b;
        eq = req_q.corner_c;
      end
      default: begin
        ep = req_q.corner_c;
        eq = req_q.corner_a;
      end
    endcase
    elo = (ep < eq) ? ep : eq;
    ehi = (ep < eq) ? eq : ep;
  end

  always_comb begin
    case (cnt2_q)
      2'd0:    csel = sx_q;
      2'd1:    csel = sy_q;
      default: csel = sz_q;
    endcase
    mag    = csel[16] ? 16'(-csel) : csel[15:0];
    prod   = csel * csel;
    s_next = s_q + prod[31:0];
    trial  = {1'b0, r_q} + {1'b0, bit_q};
    quo_n  = {quo_q[14:0], (num_q >= dvs_q)};
    qsat   = (quo_n > OneQ14) ? OneQ14 : quo_n;
  end

  always_comb begin
    zres = '0;
    state_d = state_q;
    init_d  = init_q;
    count_d = count_q;
    req_d   = req_q;
    edge_d  = edge_q;
    p_d     = p_q;
    q_d     = q_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    slot_d  = slot_q;
    mid_d   = mid_q;
    av_d    = av_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    sz_d    = sz_q;
    cnt2_d  = cnt2_q;
    s_d     = s_q;
    v_d     = v_q;
    r_d     = r_q;
    bit_d   = bit_q;
    num_d   = num_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    dcnt_d  = dcnt_q;
    nv_d    = nv_q;
    ov_d    = 1'b0;
    out_d   = out_q;
    vwe     = 1'b0;
    vwaddr  = count_q[IdxW-1:0];
    vwdata  = nv_q;
    vraddr  = q_q;
    cwe     = 1'b0;
    cwaddr  = slot_q;
    cwdata  = {1'b1, lo_q, hi_q, count_q[IdxW-1:0]};

    case (state_q)
      SInit: begin
        cwe    = 1'b1;
        cwaddr = init_q;
        cwdata = '0;
        vwe    = (init_q < IdxW'(SeedCount));
        vwaddr = init_q;
        vwdata = seed_vtx(init_q[3:0]);
        init_d = init_q + 1'b1;
        if (init_q == IdxW'(CacheDepth - 1)) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (start) begin
          req_d  = req_i;
          edge_d = 2'd0;
          if (req_i.req_type == ReqRead) begin
            if ({1'b0, req_i.corner_a} >= count_q) begin
              ov_d         = 1'b1;
              out_d        = zres;
              out_d.status = StRange;
              out_d.last   = 1'b1;
            end else begin
              state_d = SRdv;
            end
          end else if (({1'b0, req_i.corner_a} >= count_q) ||
                       ({1'b0, req_i.corner_b} >= count_q) ||
                       ({1'b0, req_i.corner_c} >= count_q)) begin
            ov_d         = 1'b1;
            out_d        = zres;
            out_d.status = StRange;
            out_d.last   = 1'b1;
          end else if (req_i.face_level >= tgt_eff) begin
            ov_d            = 1'b1;
            out_d           = zres;
            out_d.out_a     = req_i.corner_a;
            out_d.out_b     = req_i.corner_b;
            out_d.out_c     = req_i.corner_c;
            out_d.out_level = req_i.face_level;
            out_d.status    = StOk;
            out_d.last      = 1'b1;
          end else begin
            state_d = SEdge;
          end
        end
      end
      SRdv: begin
        vraddr  = req_q.corner_a;
        state_d = SRdOut;
      end
      SRdOut: begin
        ov_d          = 1'b1;
        out_d         = zres;
        out_d.coord_x = vrdata[47:32];
        out_d.coord_y = vrdata[31:16];
        out_d.coord_z = vrdata[15:0];
        out_d.status  = StOk;
        out_d.last    = 1'b1;
        state_d       = SIdle;
      end
      SEdge: begin
        p_d     = ep;
        q_d     = eq;
        lo_d    = elo;
        hi_d    = ehi;
        slot_d  = elo ^ {ehi[6:0], ehi[13:7]};
        state_d = SProbe;
      end
      SProbe: begin
        state_d = SChk;
      end
      SChk: begin
        if (crdata[EntryW-1] && (crdata[41:28] == lo_q) && (crdata[27:14] == hi_q)) begin
          mid_d[edge_q] = crdata[13:0];
          if (edge_q == 2'd2) begin
            cnt2_d  = 2'd0;
            state_d = SEmit;
          end else begin
            edge_d  = edge_q + 1'b1;
            state_d = SEdge;
          end
        end else if (crdata[EntryW-1]) begin
          slot_d  = slot_q + 1'b1;
          state_d = SProbe;
        end else if (count_q[CountW-1]) begin
          ov_d         = 1'b1;
          out_d        = zres;
          out_d.status = StStoreFull;
          out_d.last   = 1'b1;
          state_d      = SIdle;
        end else begin
          state_d = SRdp;
        end
      end
      SRdp: begin
        vraddr  = p_q;
        state_d = SRdq;
      end
      SRdq: begin
        vraddr  = q_q;
        av_d    = vrdata;
        state_d = SSum;
      end
      SSum: begin
        sx_d    = sext17(av_q[47:32]) + sext17(vrdata[47:32]);
        sy_d    = sext17(av_q[31:16]) + sext17(vrdata[31:16]);
        sz_d    = sext17(av_q[15:0]) + sext17(vrdata[15:0]);
        s_d     = '0;
        cnt2_d  = 2'd0;
        state_d = SSq;
      end
      SSq: begin
        s_d    = s_next;
        cnt2_d = cnt2_q + 1'b1;
        if (cnt2_q == 2'd2) begin
          if (s_next == '0) begin
            nv_d    = '0;
            state_d = SWr;
          end else begin
            v_d     = {s_next, 28'd0};
            r_d     = '0;
            bit_d   = 60'd1 << 58;
            state_d = SSqrt;
          end
        end
      end
      SSqrt: begin
        if ({1'b0, v_q} >= trial) begin
          v_d = v_q - trial[59:0];
          r_d = (r_q >> 1) + bit_q;
        end else begin
          r_d = r_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q == 60'd1) begin
          cnt2_d  = 2'd0;
          state_d = SDivI;
        end
      end
      SDivI: begin
        num_d   = 47'({mag, 28'd0}) + 47'(len[30:1]);
        dvs_d   = 47'({len, 15'd0});
        quo_d   = '0;
        dcnt_d  = '0;
        state_d = SDiv;
      end
      SDiv: begin
        if (num_q >= dvs_q) begin
          num_d = num_q - dvs_q;
        end
        quo_d  = quo_n;
        dvs_d  = dvs_q >> 1;
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == 4'd15) begin
          nv_d[2 - cnt2_q] = csel[16] ? 16'(-qsat) : qsat;
          if (cnt2_q == 2'd2) begin
            state_d = SWr;
          end else begin
            cnt2_d  = cnt2_q + 1'b1;
            state_d = SDivI;
          end
        end
      end
      SWr: begin
        vwe           = 1'b1;
        cwe           = 1'b1;
        mid_d[edge_q] = count_q[IdxW-1:0];
        count_d       = count_q + 1'b1;
        if (edge_q == 2'd2) begin
          cnt2_d  = 2'd0;
          state_d = SEmit;
        end else begin
          edge_d  = edge_q + 1'b1;
          state_d = SEdge;
        end
      end
      SEmit: begin
        ov_d            = 1'b1;
        out_d           = zres;
        out_d.out_level = req_q.face_level + 1'b1;
        out_d.status    = StOk;
        case (cnt2_q)
          2'd0: begin
            out_d.out_a = mid_q[0];
            out_d.out_b = mid_q[1];
            out_d.out_c = mid_q[2];
          end
          2'd1: begin
            out_d.out_a = req_q.corner_a;
            out_d.out_b = mid_q[0];
            out_d.out_c = mid_q[2];
          end
          2'd2: begin
            out_d.out_a = req_q.corner_b;
            out_d.out_b = mid_q[1];
            out_d.out_c = mid_q[0];
          end
          default: begin
            out_d.out_a = req_q.corner_c;
            out_d.out_b = mid_q[2];
            out_d.out_c = mid_q[1];
            out_d.last  = 1'b1;
            state_d     = SIdle;
          end
        endcase
        cnt2_d = cnt2_q + 1'b1;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit;
      init_q  <= '0;
      tgt_q   <= 3'd1;
      count_q <= CountW'(SeedCount);
      ov_q    <= 1'b0;
      edge_q  <= '0;
      cnt2_q  <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      count_q <= count_d;
      ov_q    <= ov_d;
      edge_q  <= edge_d;
      cnt2_q  <= cnt2_d;
      dcnt_q  <= dcnt_d;
      if (cfg_we_i) begin
        tgt_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    p_q    <= p_d;
    q_q    <= q_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    slot_q <= slot_d;
    mid_q  <= mid_d;
    av_q   <= av_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    sz_q   <= sz_d;
    s_q    <= s_d;
    v_q    <= v_d;
    r_q    <= r_d;
    bit_q  <= bit_d;
    num_q  <= num_d;
    dvs_q  <= dvs_d;
    quo_q  <= quo_d;
    nv_q   <= nv_d;
    out_q  <= out_d;
  end

endmodule

// File: sv/isd_ram.sv
// ----------------------------------------------------------------------------
// isd_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module isd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: tb/face_split_checker.sv
// ----------------------------------------------------------------------------
// face_split_checker
// Watches the request and result channels of the icosphere face subdivider.
// It keeps its own vertex store and edge-midpoint cache, and works out the
// faces or coordinates that each request must return. Each returned result is
// compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module face_split_checker import isd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  req_t              req_i,
  input  logic              cfg_we_i,
  input  logic [LevelW-1:0] cfg_wdata_i,
  input  logic              result_valid_i,
  input  res_t              result_i,
  output int                fail_cnt_o,
  output int                pending_o,
  output int                vtx_count_o,
  output int                result_cnt_o
);

  int vx [StoreDepth];
  int vy [StoreDepth];
  int vz [StoreDepth];
  int midpoint_of [bit [27:0]];
  int cache_fill;
  int fail_cnt;
  int pending;
  int vtx_count;
  int result_cnt;
  logic [LevelW-1:0] split_depth;
  res_t expected_results [$];

  assign fail_cnt_o   = fail_cnt;
  assign pending_o    = pending;
  assign vtx_count_o  = vtx_count;
  assign result_cnt_o = result_cnt;

  function automatic void add_expected(res_t r);
    expected_results = {expected_results, r};
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int scale_comp(int c, longint unsigned len);
    longint unsigned mag;
    longint unsigned q;
    mag = (c < 0) ? longint'(-c) : longint'(c);
    q = ((mag << 28) + len / 2) / len;
    if (q > 16384) q = 16384;
    return (c < 0) ? -int'(q) : int'(q);
  endfunction

  function automatic status_e split_edge(int p, int q, output int mid);
    int lo;
    int hi;
    int sx;
    int sy;
    int sz;
    longint unsigned s;
    longint unsigned len;
    bit [27:0] key;
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
    key = {lo[13:0], hi[13:0]};
    mid = 0;
    if (midpoint_of.exists(key)) begin
      mid = midpoint_of[key];
      return StOk;
    end
    if (vtx_count >= StoreDepth) return StStoreFull;
    if (cache_fill >= CacheDepth) return StCacheFull;
    sx = vx[p] + vx[q];
    sy = vy[p] + vy[q];
    sz = vz[p] + vz[q];
    s = longint'(sx) * sx + longint'(sy) * sy + longint'(sz) * sz;
    vx[vtx_count] = 0;
    vy[vtx_count] = 0;
    vz[vtx_count] = 0;
    if (s != 0) begin
      len = int_sqrt(s << 28);
      vx[vtx_count] = scale_comp(sx, len);
      vy[vtx_count] = scale_comp(sy, len);
      vz[vtx_count] = scale_comp(sz, len);
    end
    midpoint_of[key] = vtx_count;
    cache_fill++;
    mid = vtx_count;
    vtx_count++;
    return StOk;
  endfunction

  function automatic res_t face_res(int a, int b, int c, int lvl, bit fin);
    res_t r;
    r = '0;
    r.out_a = a[IdxW-1:0];
    r.out_b = b[IdxW-1:0];
    r.out_c = c[IdxW-1:0];
    r.out_level = lvl[LevelW-1:0];
    r.status = StOk;
    r.last = fin;
    return r;
  endfunction

  function automatic res_t fault_res(status_e st);
    res_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic predict_request(req_t rq);
    int a;
    int b;
    int c;
    int lvl;
    int eff;
    int ab;
    int bc;
    int ca;
    status_e st;
    res_t r;
    a = rq.corner_a;
    b = rq.corner_b;
    c = rq.corner_c;
    lvl = rq.face_level;
    eff = (split_depth < MaxLevel) ? split_depth : MaxLevel;
    if (rq.req_type == ReqRead) begin
      if (a >= vtx_count) begin
        add_expected(fault_res(StRange));
      end else begin
        r = '0;
        r.coord_x = vx[a][CoordW-1:0];
        r.coord_y = vy[a][CoordW-1:0];
        r.coord_z = vz[a][CoordW-1:0];
        r.status = StOk;
        r.last = 1'b1;
        add_expected(r);
      end
    end else if (a >= vtx_count || b >= vtx_count || c >= vtx_count) begin
      add_expected(fault_res(StRange));
    end else if (lvl >= eff) begin
      add_expected(face_res(a, b, c, lvl, 1'b1));
    end else begin
      st = split_edge(a, b, ab);
      if (st == StOk) st = split_edge(b, c, bc);
      if (st == StOk) st = split_edge(c, a, ca);
      if (st != StOk) begin
        add_expected(fault_res(st));
      end else begin
        add_expected(face_res(ab, bc, ca, lvl + 1, 1'b0));
        add_expected(face_res(a, ab, ca, lvl + 1, 1'b0));
        add_expected(face_res(b, bc, ab, lvl + 1, 1'b0));
        add_expected(face_res(c, ca, bc, lvl + 1, 1'b1));
      end
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_cnt++;
  endtask

  task automatic check_result(res_t got);
    res_t w;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result", got.status, -1);
      return;
    end
    w = expected_results.pop_front();
    if (got.out_a !== w.out_a) report_mismatch("out_a", got.out_a, w.out_a);
    if (got.out_b !== w.out_b) report_mismatch("out_b", got.out_b, w.out_b);
    if (got.out_c !== w.out_c) report_mismatch("out_c", got.out_c, w.out_c);
    if (got.out_level !== w.out_level)
      report_mismatch("out_level", got.out_level, w.out_level);
    if (got.coord_x !== w.coord_x) report_mismatch("coord_x", got.coord_x, w.coord_x);
    if (got.coord_y !== w.coord_y) report_mismatch("coord_y", got.coord_y, w.coord_y);
    if (got.coord_z !== w.coord_z) report_mismatch("coord_z", got.coord_z, w.coord_z);
    if (got.status !== w.status) report_mismatch("status", got.status, w.status);
    if (got.last !== w.last) report_mismatch("last", got.last, w.last);
  endtask

  initial begin
    int seed_tab [SeedCount][3];
    seed_tab = '{'{-8614, 13937, 0}, '{8614, 13937, 0}, '{-8614, -13937, 0},
                 '{8614, -13937, 0}, '{0, -8614, 13937}, '{0, 8614, 13937},
                 '{0, -8614, -13937}, '{0, 8614, -13937}, '{13937, 0, -8614},
                 '{13937, 0, 8614}, '{-13937, 0, -8614}, '{-13937, 0, 8614}};
    for (int k = 0; k < SeedCount; k++) begin
      vx[k] = seed_tab[k][0];
      vy[k] = seed_tab[k][1];
      vz[k] = seed_tab[k][2];
    end
    vtx_count = SeedCount;
    cache_fill = 0;
    split_depth = 3'd1;
    fail_cnt = 0;
    pending = 0;
    result_cnt = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) split_depth = cfg_wdata_i;
      if (start && !busy) predict_request(req_i);
      if (result_valid_i) begin
        check_result(result_i);
        result_cnt++;
      end
      pending = expected_results.size();
    end
  end

endmodule

// File: tb/icosphere_face_subdivider_tb.sv
// ----------------------------------------------------------------------------
// icosphere_face_subdivider_tb
// Drives directed and random split and read requests into the subdivider
// under several target depths and sender gap rates; a separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icosphere_face_subdivider_tb;
  import isd_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  req_t              req;
  logic              cfg_we;
  logic [LevelW-1:0] cfg_wdata;
  logic              res_valid;
  res_t              res;
  int                fail_cnt;
  int                pending;
  int                vtx_count;
  int                result_cnt;
  int                sent;
  int                cur_target;
  int                idle_pct;

  icosphere_face_subdivider u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .result_valid_o (res_valid),
    .result_o       (res)
  );

  face_split_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .result_valid_i (res_valid),
    .result_i       (res),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending),
    .vtx_count_o    (vtx_count),
    .result_cnt_o   (result_cnt)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #30ms;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_request(req_type_e kind, int a, int b, int c, int lvl);
    start <= 1'b1;
    req <= '{req_type: kind, corner_a: a[IdxW-1:0], corner_b: b[IdxW-1:0],
             corner_c: c[IdxW-1:0], face_level: lvl[LevelW-1:0]};
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_target(int value);
    cur_target = value;
    cfg_we <= 1'b1;
    cfg_wdata <= value[LevelW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_request();
    int pick;
    int eff;
    int a;
    int b;
    int c;
    int lvl;
    pick = $urandom_range(99);
    eff = (cur_target < 5) ? cur_target : 5;
    if (pick < 10) begin
      a = ($urandom_range(3) == 0) ? $urandom_range(16383) : $urandom_range(vtx_count + 4);
      send_request(ReqRead, a, $urandom_range(16383), $urandom_range(16383),
                   $urandom_range(7));
    end else if (pick < 16) begin
      send_request(ReqSplit, $urandom_range(16383), $urandom_range(16383),
                   $urandom_range(16383), $urandom_range(7));
    end else begin
      if ($urandom_range(1) == 0) begin
        a = $urandom_range(11);
        b = $urandom_range(11);
        c = $urandom_range(11);
      end else begin
        a = $urandom_range(vtx_count - 1);
        b = $urandom_range(vtx_count - 1);
        c = $urandom_range(vtx_count - 1);
      end
      if ($urandom_range(9) == 0) lvl = $urandom_range(7);
      else lvl = (eff == 0) ? 0 : $urandom_range(eff - 1);
      send_request(ReqSplit, a, b, c, lvl);
    end
  endtask

  initial begin
    int gap_rates [5];
    int targets [5];
    gap_rates = '{0, 70, 17, 0, 70};
    targets = '{3, 0, 7, 2, 5};
    rst_n = 1'b0;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sent = 0;
    cur_target = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_request(ReqRead, 0, 0, 0, 0);
    send_request(ReqRead, 11, 16383, 16383, 7);
    send_request(ReqRead, 12, 0, 0, 0);
    send_request(ReqRead, 16383, 0, 0, 0);
    send_request(ReqSplit, 0, 1, 5, 0);
    send_request(ReqSplit, 5, 1, 0, 0);
    send_request(ReqSplit, 0, 3, 5, 0);
    send_request(ReqSplit, 4, 4, 9, 0);
    send_request(ReqSplit, 2, 6, 10, 1);
    send_request(ReqSplit, 2, 6, 10, 7);
    send_request(ReqSplit, 16383, 1, 2, 0);
    send_request(ReqSplit, 1, 16383, 2, 0);
    send_request(ReqSplit, 1, 2, 16383, 0);
    send_request(ReqRead, 12, 0, 0, 0);
    send_request(ReqRead, 14, 0, 0, 0);
    send_request(ReqRead, 16, 0, 0, 0);
    send_request(ReqRead, 21, 0, 0, 0);
    drain_results();

    for (int ph = 0; ph < 5; ph++) begin
      write_target(targets[ph]);
      idle_pct = gap_rates[ph];
      for (int n = 0; n < 70; n++) begin
        if (ph == 1 && n == 35) drain_results();
        if ($urandom_range(99) < idle_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 40)) @(posedge clk);
        end
        random_request();
      end
      drain_results();
    end

    repeat (200) @(posedge clk);
    $display("Sent %0d requests over target depths 0 to 7 with sender gaps of 0 to 70%%;",
             sent);
    $display("checked %0d results, vertex store grew to %0d entries.",
             result_cnt, vtx_count);
    if (fail_cnt == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
sv/isd_pkg.sv
sv/isd_ram.sv
sv/icosphere_face_subdivider.sv
tb/face_split_checker.sv
tb/icosphere_face_subdivider_tb.sv
